// File: design/kmte_pkg.sv
// Package: constants, field widths and opcode codes for the keyed multitape Turing evaluator.
package kmte_pkg;

	localparam int TAPE_COUNT          = 5;
	localparam int STATE_BITS          = 3;
	localparam int STEP_COUNT          = 32;
	localparam int PAD_BITS            = 10;
	localparam int INPUT_BITS_PER_TAPE = 3;

	localparam int TAPE_LEN    = 2 * STEP_COUNT + 4 * INPUT_BITS_PER_TAPE;
	localparam int HEAD_START  = STEP_COUNT + INPUT_BITS_PER_TAPE;
	localparam int WIN_LEN     = 2 * TAPE_LEN;
	localparam int WIN_CTR     = TAPE_LEN;
	localparam int WIN_BASE    = WIN_CTR - HEAD_START;

	localparam int ARG_W       = TAPE_COUNT * INPUT_BITS_PER_TAPE;
	localparam int IDX_W       = STATE_BITS + TAPE_COUNT;
	localparam int ENTRY_W     = STATE_BITS + 2 * TAPE_COUNT;
	localparam int TABLE_DEPTH = 1 << IDX_W;
	localparam int STEP_W      = $clog2(STEP_COUNT + 1);

	localparam int ARG_LSB     = 0;
	localparam int IDX_LSB     = ARG_LSB + ARG_W;
	localparam int WORD_LSB    = IDX_LSB + IDX_W;
	localparam int S_TDATA_W   = ((WORD_LSB + ENTRY_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = 8;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_ADDR_W  = $clog2(4 * TAPE_COUNT);
	localparam int CFG_IDX_W   = CFG_ADDR_W - 2;

	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic [TAPE_COUNT-1:0][WIN_LEN-1:0] tape_win_t;

endpackage

// File: design/keyed_multitape_turing_evaluator_core.sv
// Top level: keyed multitape Turing evaluator with transition table, tapes and step sequencer.
// Write item: stored in the table when it is transferred, no result.
// Evaluate item: result raised from the done state once the output register is free; each machine
// step is a registered read of the transition table memory (ST_RD) followed by an update (ST_UPD).
// A new item is taken only while the sequencer is idle; writes are taken every cycle while it is idle.
// Reset clears sequencer, pad registers and output valid; the table is undefined until written.
module keyed_multitape_turing_evaluator_core
	import kmte_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// argument [14:0], entry_index [22:15], entry_word [35:23], zero fill above
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// result_bit [0], zero fill above
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [STEP_W-1:0]     step_q;
	logic [STATE_BITS-1:0] mstate_q;
	logic                  m_tvalid_q;
	logic                  result_q;
	logic [PAD_BITS-1:0]   pad_q [TAPE_COUNT];

	logic [ENTRY_W-1:0]    trans_mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0]    entry_q;
	tape_win_t             tape_q;
	tape_win_t             tape_load;
	tape_win_t             tape_wr;
	tape_win_t             tape_next;
	logic [TAPE_COUNT-1:0] seen;

	logic                  in_xfer;
	logic                  cfg_wr;
	logic [CFG_IDX_W-1:0]  cfg_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, result_q};
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[CFG_ADDR_W-1:2];

	always_comb begin
		prdata = '0;
		if (32'(cfg_idx) < TAPE_COUNT) begin
			prdata = {{(CFG_DATA_W-PAD_BITS){1'b0}}, pad_q[cfg_idx]};
		end
	end

	// initial tape image: argument twice, pads either side, head cell at the window centre
	always_comb begin
		tape_load = '0;
		for (int t = 0; t < TAPE_COUNT; t++) begin
			for (int k = 0; k < INPUT_BITS_PER_TAPE; k++) begin
				tape_load[t][WIN_BASE + STEP_COUNT + k] =
					s_tdata[ARG_LSB + t * INPUT_BITS_PER_TAPE + k];
				tape_load[t][WIN_BASE + STEP_COUNT + INPUT_BITS_PER_TAPE + k] =
					s_tdata[ARG_LSB + t * INPUT_BITS_PER_TAPE + k];
			end
			for (int k = 0; k < PAD_BITS; k++) begin
				if (STEP_COUNT - PAD_BITS + k >= 0) begin
					tape_load[t][WIN_BASE + STEP_COUNT - PAD_BITS + k] = pad_q[t][k];
				end
				if (STEP_COUNT + 2 * INPUT_BITS_PER_TAPE + k < TAPE_LEN) begin
					tape_load[t][WIN_BASE + STEP_COUNT + 2 * INPUT_BITS_PER_TAPE + k] =
						pad_q[t][k];
				end
			end
		end
	end

	// write symbol under head, then shift the window against the head move
	always_comb begin
		tape_wr   = tape_q;
		tape_next = tape_q;
		for (int t = 0; t < TAPE_COUNT; t++) begin
			seen[t] = tape_q[t][WIN_CTR];
			tape_wr[t][WIN_CTR] = entry_q[TAPE_COUNT + t];
			if (entry_q[t]) begin
				tape_next[t] = {1'b0, tape_wr[t][WIN_LEN-1:1]};
			end else begin
				tape_next[t] = {tape_wr[t][WIN_LEN-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_tuser == OP_WRITE) begin
			trans_mem[s_tdata[IDX_LSB +: IDX_W]] <= s_tdata[WORD_LSB +: ENTRY_W];
		end
		if (state_q == ST_RD) begin
			entry_q <= trans_mem[{mstate_q, seen}];
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_tuser == OP_EVAL) begin
			tape_q <= tape_load;
		end else if (state_q == ST_UPD) begin
			tape_q <= tape_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAPE_COUNT; t++) begin
				pad_q[t] <= '0;
			end
		end else if (cfg_wr && 32'(cfg_idx) < TAPE_COUNT) begin
			pad_q[cfg_idx] <= pwdata[PAD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			mstate_q   <= '0;
			m_tvalid_q <= 1'b0;
			result_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && s_tuser == OP_EVAL) begin
						mstate_q <= '0;
						step_q   <= '0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					mstate_q <= entry_q[2*TAPE_COUNT +: STATE_BITS];
					step_q   <= step_q + 1'b1;
					if (step_q == STEP_W'(STEP_COUNT - 1)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						result_q   <= mstate_q[0];
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tuser == OP_EVAL) |=> (state_q == ST_RD && step_q == '0))
		else $error("evaluation did not start at step zero");

	a_rd_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_UPD))
		else $error("table read not followed by update");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && step_q == STEP_W'(STEP_COUNT - 1)) |=> (state_q == ST_DONE))
		else $error("sequencer missed the final step");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

endmodule
